// File: rtl/mkh_pkg.sv
`timescale 1ns / 1ps
package mkh_pkg;

   localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
   localparam int unsigned MIX_SHIFT   = 24;
   localparam int unsigned FIN_SHIFT_A = 13;
   localparam int unsigned FIN_SHIFT_B = 15;

   localparam int unsigned WORD_W   = 32;
   localparam int unsigned NBYTES_W = 3;
   localparam int unsigned REQ_DATA_W = 72;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_NONE,
      OP_FULL,
      OP_TAIL
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MIX1,
      ST_MIX2,
      ST_FOLD,
      ST_TAIL,
      ST_FIN1,
      ST_FIN2
   } state_type;

   typedef struct packed {
      op_type            op;
      logic [WORD_W-1:0] word;
      logic              first;
      logic              last;
      logic [WORD_W-1:0] klen;
   } entry_type;

endpackage

// File: rtl/mkh_front.sv
`timescale 1ns / 1ps
module mkh_front (
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [mkh_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                              req_tuser,
   input  logic                              req_tlast,
   input  logic                              q_full,
   output logic                              push,
   output mkh_pkg::entry_type                push_entry
);
   import mkh_pkg::*;

   logic [WORD_W-1:0]   key_word;
   logic [NBYTES_W-1:0] bytes_valid;
   logic [WORD_W-1:0]   key_length;
   logic [WORD_W-1:0]   mask;
   op_type              op;

   assign key_word    = req_tdata[31:0];
   assign bytes_valid = req_tdata[34:32];
   assign key_length  = req_tdata[66:35];

   assign req_tready = !q_full;
   assign push       = req_tvalid && !q_full;

   // counts of five to seven act as a full word
   always_comb begin
      case (bytes_valid)
         3'd0: begin
            op   = OP_NONE;
            mask = '0;
         end
         3'd1: begin
            op   = OP_TAIL;
            mask = 32'h0000_00ff;
         end
         3'd2: begin
            op   = OP_TAIL;
            mask = 32'h0000_ffff;
         end
         3'd3: begin
            op   = OP_TAIL;
            mask = 32'h00ff_ffff;
         end
         default: begin
            op   = OP_FULL;
            mask = '1;
         end
      endcase
   end

   always_comb begin
      push_entry.op    = op;
      push_entry.word  = key_word & mask;
      push_entry.first = req_tuser;
      push_entry.last  = req_tlast;
      push_entry.klen  = key_length;
   end

endmodule

// File: rtl/mkh_queue.sv
`timescale 1ns / 1ps
module mkh_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  mkh_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output mkh_pkg::entry_type head
);
   import mkh_pkg::*;

   entry_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_pop;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = slot_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: rtl/mkh_back.sv
`timescale 1ns / 1ps
module mkh_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [mkh_pkg::WORD_W-1:0]   csr_wdata,
   input  logic                         head_valid,
   input  mkh_pkg::entry_type           head,
   output logic                         pop,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [mkh_pkg::WORD_W-1:0]   rsp_tdata
);
   import mkh_pkg::*;

   state_type         state_ff, state_in;
   logic [WORD_W-1:0] seed_ff;
   logic [WORD_W-1:0] h_ff, h_in;
   logic [WORD_W-1:0] hm_ff;
   logic [WORD_W-1:0] k_ff, k_in;
   logic [WORD_W-1:0] w_ff;
   logic [WORD_W-1:0] p_ff;
   logic              last_ff;
   logic              rsp_tvalid_ff, rsp_tvalid_in;
   logic [WORD_W-1:0] rsp_tdata_ff;
   logic              out_free;

   logic do_mix1, do_mix2, do_fold, do_tail, do_fin1, do_emit;

   logic [WORD_W-1:0] k_shr;
   logic [WORD_W-1:0] h_fin;
   logic [WORD_W-1:0] p_fin;

   assign out_free = !rsp_tvalid_ff || rsp_tready;
   assign k_shr    = k_ff ^ (k_ff >> MIX_SHIFT);
   assign h_fin    = h_ff ^ (h_ff >> FIN_SHIFT_A);
   assign p_fin    = p_ff ^ (p_ff >> FIN_SHIFT_B);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               case (head.op)
                  OP_FULL: state_in = ST_MIX1;
                  OP_TAIL: state_in = ST_TAIL;
                  default: state_in = head.last ? ST_FIN1 : ST_IDLE;
               endcase
            end
         end
         ST_MIX1: state_in = ST_MIX2;
         ST_MIX2: state_in = ST_FOLD;
         ST_FOLD: state_in = last_ff ? ST_FIN1 : ST_IDLE;
         ST_TAIL: state_in = last_ff ? ST_FIN1 : ST_IDLE;
         ST_FIN1: state_in = ST_FIN2;
         ST_FIN2: state_in = out_free ? ST_IDLE : ST_FIN2;
         default: state_in = ST_IDLE;
      endcase
   end

   // per-state controls
   always_comb begin
      pop     = 1'b0;
      do_mix1 = 1'b0;
      do_mix2 = 1'b0;
      do_fold = 1'b0;
      do_tail = 1'b0;
      do_fin1 = 1'b0;
      do_emit = 1'b0;
      case (state_ff)
         ST_IDLE: pop     = head_valid;
         ST_MIX1: do_mix1 = 1'b1;
         ST_MIX2: do_mix2 = 1'b1;
         ST_FOLD: do_fold = 1'b1;
         ST_TAIL: do_tail = 1'b1;
         ST_FIN1: do_fin1 = 1'b1;
         ST_FIN2: do_emit = out_free;
         default: pop     = 1'b0;
      endcase
   end

   always_comb begin
      h_in = h_ff;
      if (pop) begin
         h_in = head.first ? (seed_ff ^ head.klen) : h_ff;
      end else if (do_fold) begin
         h_in = hm_ff ^ k_ff;
      end else if (do_tail) begin
         h_in = (h_ff ^ w_ff) * MIX_MUL;
      end
   end

   always_comb begin
      k_in = k_ff;
      if (do_mix1) begin
         k_in = w_ff * MIX_MUL;
      end else if (do_mix2) begin
         k_in = k_shr * MIX_MUL;
      end
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (do_emit) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         seed_ff       <= '0;
         h_ff          <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         h_ff          <= h_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (csr_we) begin
            seed_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      k_ff <= k_in;
      if (pop) begin
         w_ff    <= head.word;
         last_ff <= head.last;
      end
      if (do_mix2) begin
         hm_ff <= h_ff * MIX_MUL;
      end
      if (do_fin1) begin
         p_ff <= h_fin * MIX_MUL;
      end
      if (do_emit) begin
         rsp_tdata_ff <= p_fin;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

// File: rtl/murmur2_key_hash.sv
`timescale 1ns / 1ps
// path to rsp_tvalid: a req transfer writes a word into the queue, where it may wait until the
// sequencer pops it in ST_IDLE; a full word then runs ST_MIX1, ST_MIX2, ST_FOLD, a tail word
// ST_TAIL, an empty word nothing more; a last word then passes ST_FIN1 and ST_FIN2, which waits
// for a free output; new words are popped only in ST_IDLE, and a 4-entry queue absorbs bursts
// reset: synchronous, active high; clears seed, running hash, queue and rsp_tvalid
module murmur2_key_hash (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [mkh_pkg::WORD_W-1:0]        csr_wdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // key_word [31:0], bytes_valid [34:32], key_length [66:35], zero [71:67]
   input  logic [mkh_pkg::REQ_DATA_W-1:0]    req_tdata,
   // first_word [0]
   input  logic                              req_tuser,
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // hash_value [31:0]
   output logic [mkh_pkg::WORD_W-1:0]        rsp_tdata
);
   import mkh_pkg::*;

   logic      q_full;
   logic      push;
   entry_type push_entry;
   logic      pop;
   logic      head_valid;
   entry_type head;

   mkh_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .push       (push),
      .push_entry (push_entry)
   );

   mkh_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   mkh_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// File: rtl/mkh_checker.sv
`timescale 1ns / 1ps
module mkh_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              req_tlast,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [mkh_pkg::WORD_W-1:0]        rsp_tdata
);
   import mkh_pkg::*;

   // last words taken in but not yet answered
   logic [3:0] pending_ff, pending_in;
   logic       last_xfer;
   logic       rsp_xfer;

   assign last_xfer = req_tvalid && req_tready && req_tlast;
   assign rsp_xfer  = rsp_tvalid && rsp_tready;

   always_comb begin
      pending_in = pending_ff;
      if (last_xfer && !rsp_xfer) begin
         pending_in = pending_ff + 1'b1;
      end else if (!last_xfer && rsp_xfer && pending_ff != '0) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped without a transfer");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("rsp_tdata changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pending_ff != '0)
      else $error("hash presented without a pending last word");

endmodule

bind murmur2_key_hash mkh_checker u_mkh_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
